// ----- sv/fbu_pkg.sv -----
// Package for the fire blur-up filter unit: payload types, queue entry type,
// register indexes and reset values. No dependencies.
`default_nettype none
package fbu_pkg;

   localparam int HEAT_W = 8;
   localparam int CFG_W = 11;
   localparam int SUM_W = HEAT_W + 3;
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 11'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

   localparam logic CSR_LINE_WIDTH = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [HEAT_W-1:0] heat_in;
      logic              frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [HEAT_W-1:0] heat_out;
      logic              line_end;
      logic              frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic             we;
      logic             index;
      logic [CFG_W-1:0] wdata;
   } csr_write_type;

   typedef struct packed {
      logic [HEAT_W-1:0] heat;
      logic              has_main;
      logic              has_tail;
      logic              tail_frame_end;
   } entry_type;

endpackage
`default_nettype wire

// ----- sv/fire_blur_up_filter_unit.sv -----
// Fire blur-up filter top level: front, queue and back parts.
// The stage-1 register, the queue and the output register lie between an accepted source
// word and its result word; output row r follows source row r+2.
// Throughput: one word per cycle while the queue has room; the line-end word adds a
// second result, which the four-entry queue absorbs. Reset is synchronous: it clears the
// counters, the window and the queue, and loads 640 by 480; line memories keep their contents.
`default_nettype none
module fire_blur_up_filter_unit import fbu_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_payload_type       rsp_data
);

   csr_write_type csr;
   entry_type     push_entry, head;
   logic          push_valid, queue_full, queue_empty, pop;

   assign csr.we = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   fbu_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .queue_full(queue_full)
   );

   fbu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   fbu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (queue_empty),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sv/fbu_front.sv -----
// Front part of the fire blur-up filter: position counters, line memories,
// 3x3 window and result classification. Depends on fbu_pkg.
`default_nettype none
module fbu_front import fbu_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire csr_write_type   csr,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 push_valid,
   output entry_type            push_entry,
   input  wire logic            queue_full
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WCMP = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
   localparam int HCMP = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);

   logic [CFG_W-1:0] line_width_ff, frame_height_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [HEAT_W-1:0] mem_a [MAX_WIDTH];
   logic [HEAT_W-1:0] mem_b [MAX_WIDTH];
   logic [HEAT_W-1:0] rd_a_ff, rd_b_ff;
   logic              byp_ff, byp_in;
   logic [HEAT_W-1:0] byp_a_ff, byp_b_ff;

   logic              s1_valid_ff;
   logic [HEAT_W-1:0] s1_heat_ff;
   logic [CW-1:0]     s1_col_ff;
   logic              s1_main_ff, s1_zero_ff, s1_tail_ff, s1_fe_ff;
   logic              main_in, zero_in, tail_in, fe_in;

   logic [HEAT_W-1:0] win_ff [9];
   logic [HEAT_W-1:0] win_in [9];

   logic [WCMP-1:0] w_eff, c_ext, c_next;
   logic [HCMP-1:0] h_eff, r_ext, r_next;
   logic [CW-1:0]   c_cur;
   logic [RW-1:0]   r_cur;
   logic            accept, s1_push, s1_adv, in_rows;
   logic [HEAT_W-1:0] up1, up2;
   logic [SUM_W-1:0]  sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr.we) begin
         case (csr.index)
            CSR_LINE_WIDTH: line_width_ff <= csr.wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr.wdata;
            default: ;
         endcase
      end
   end

   assign accept = req_valid && req_ready;
   assign s1_push = s1_main_ff || s1_tail_ff;
   assign s1_adv = s1_valid_ff && (!s1_push || !queue_full);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      w_eff = (WCMP'(line_width_ff) < WCMP'(MAX_WIDTH)) ? WCMP'(line_width_ff)
                                                         : WCMP'(MAX_WIDTH);
      h_eff = (HCMP'(frame_height_ff) < HCMP'(MAX_HEIGHT)) ? HCMP'(frame_height_ff)
                                                           : HCMP'(MAX_HEIGHT);
      c_cur = req_data.frame_start ? '0 : col_ff;
      r_cur = req_data.frame_start ? '0 : row_ff;
      c_ext = WCMP'(c_cur);
      r_ext = HCMP'(r_cur);
      c_next = c_ext + WCMP'(1);
      r_next = r_ext + HCMP'(1);
      in_rows = (r_ext >= HCMP'(2)) && (r_ext < h_eff) && (c_ext < w_eff)
                && (c_ext != '0);
      main_in = in_rows;
      zero_in = (c_ext == WCMP'(1));
      tail_in = in_rows && (c_next == w_eff);
      fe_in = (r_next == h_eff);
      if ((c_next >= w_eff) || (c_next >= WCMP'(MAX_WIDTH))) begin
         col_in = '0;
         row_in = (r_next >= h_eff) ? '0 : RW'(r_next);
      end else begin
         col_in = CW'(c_next);
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_heat_ff <= req_data.heat_in;
         s1_col_ff <= c_cur;
         s1_main_ff <= main_in;
         s1_zero_ff <= zero_in;
         s1_tail_ff <= tail_in;
         s1_fe_ff <= fe_in;
      end
   end

   // A read of the column that the leaving word writes in the same cycle
   // takes the written values instead of the stale memory contents.
   assign byp_in = s1_adv && (s1_col_ff == c_cur);
   assign up1 = byp_ff ? byp_a_ff : rd_a_ff;
   assign up2 = byp_ff ? byp_b_ff : rd_b_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_a_ff <= mem_a[c_cur];
         rd_b_ff <= mem_b[c_cur];
         byp_ff <= byp_in;
         byp_a_ff <= s1_heat_ff;
         byp_b_ff <= up1;
      end
      if (s1_adv) begin
         mem_a[s1_col_ff] <= s1_heat_ff;
         mem_b[s1_col_ff] <= up1;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3] = win_ff[i*3+1];
         win_in[i*3+1] = win_ff[i*3+2];
      end
      win_in[2] = up2;
      win_in[5] = up1;
      win_in[8] = s1_heat_ff;
      sum = SUM_W'(win_in[0]) + SUM_W'(win_in[2]) + SUM_W'(win_in[3])
          + SUM_W'(win_in[4]) + SUM_W'(win_in[5]) + SUM_W'(win_in[6])
          + SUM_W'(win_in[7]) + SUM_W'(win_in[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   assign push_valid = s1_valid_ff && s1_push;
   assign push_entry.heat = s1_zero_ff ? '0 : sum[SUM_W-1:3];
   assign push_entry.has_main = s1_main_ff;
   assign push_entry.has_tail = s1_tail_ff;
   assign push_entry.tail_frame_end = s1_fe_ff;

endmodule
`default_nettype wire

// ----- sv/fbu_queue.sv -----
// Short queue of classified words between the front and back parts of the
// fire blur-up filter. Depends on fbu_pkg.
`default_nettype none
module fbu_queue import fbu_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           empty,
   output entry_type      head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   entry_type      slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]  count_ff;
   logic           do_push, do_pop;

   assign full = (count_ff == NW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop = pop && !empty;
   assign head = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- sv/fbu_back.sv -----
// Back part of the fire blur-up filter: expands each queued word into one or
// two result words and holds them in the output register. Depends on fbu_pkg.
`default_nettype none
module fbu_back import fbu_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      empty,
   input  wire entry_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            phase_ff, phase_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            load, last, use_main;

   assign load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      use_main = head.has_main && !phase_ff;
      last = !use_main || !head.has_tail;
      if (use_main) begin
         rsp_data_in.heat_out = head.heat;
         rsp_data_in.line_end = 1'b0;
         rsp_data_in.frame_end = 1'b0;
      end else begin
         rsp_data_in.heat_out = '0;
         rsp_data_in.line_end = 1'b1;
         rsp_data_in.frame_end = head.tail_frame_end;
      end
      pop = load && !empty && last;
      phase_in = (load && !empty) ? !last : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            rsp_valid_ff <= !empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && !empty) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for the fire blur-up filter unit: streams pixel frames of many sizes,
// predicts every filtered word from its own model of the line stores and window,
// and checks each result word in order. Depends on fbu_pkg and the unit's RTL.
`default_nettype none
module tb_top;
   import fbu_pkg::*;

   localparam int MAX_W = MAX_WIDTH_DEFAULT;
   localparam int MAX_H = MAX_HEIGHT_DEFAULT;
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [CFG_W-1:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   req_payload_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_payload_type rsp_data;

   bit steady_flow;
   int mismatch_count;
   int pixels_sent;
   rsp_payload_type filtered_words[$];

   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [HEAT_W-1:0] row_above[MAX_W];
   logic [HEAT_W-1:0] row_above2[MAX_W];
   logic [HEAT_W-1:0] heat_window[3][3];
   int col_pos;
   int row_pos;

   fire_blur_up_filter_unit #(
      .MAX_WIDTH(MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [HEAT_W-1:0] pick_heat();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return HEAT_W'($urandom);
   endfunction

   task automatic queue_filtered(input logic [HEAT_W-1:0] heat, input logic le,
                                 input logic fe);
      rsp_payload_type word;
      word.heat_out = heat;
      word.line_end = le;
      word.frame_end = fe;
      filtered_words.push_back(word);
   endtask

   task automatic predict_pixel(input req_payload_type px);
      int w, h, c, r, sum, i;
      logic [HEAT_W-1:0] above, above2;
      w = (width_reg < MAX_W) ? width_reg : MAX_W;
      h = (height_reg < MAX_H) ? height_reg : MAX_H;
      if (px.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      above = '0;
      above2 = '0;
      if (c < MAX_W) begin
         above = row_above[c];
         above2 = row_above2[c];
         row_above2[c] = above;
         row_above[c] = px.heat_in;
      end
      for (i = 0; i < 3; i++) begin
         heat_window[i][0] = heat_window[i][1];
         heat_window[i][1] = heat_window[i][2];
      end
      heat_window[0][2] = above2;
      heat_window[1][2] = above;
      heat_window[2][2] = px.heat_in;
      if (r >= 2 && r < h && c < w) begin
         if (c == 1) begin
            queue_filtered('0, 1'b0, 1'b0);
         end else if (c >= 2) begin
            sum = heat_window[0][0] + heat_window[0][2];
            for (i = 0; i < 3; i++) sum += heat_window[1][i] + heat_window[2][i];
            queue_filtered(HEAT_W'(sum >> 3), 1'b0, 1'b0);
         end
         if (c >= 1 && c + 1 == w) queue_filtered('0, 1'b1, r + 1 == h);
      end
      if (c + 1 >= w || c + 1 >= MAX_W) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic send_pixel(input logic [HEAT_W-1:0] heat, input logic mark);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{heat_in: heat, frame_start: mark};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(req_data);
      pixels_sent++;
   endtask

   task automatic send_frame(input int total, input logic mark, input bit stray);
      int k, stray_at;
      stray_at = (stray && total > 1) ? $urandom_range(1, total - 1) : -1;
      for (k = 0; k < total; k++) begin
         send_pixel(pick_heat(), (k == 0) ? mark : (k == stray_at));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (filtered_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_size(input int w, input int h);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_LINE_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      width_reg = CFG_W'(w);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      height_reg = CFG_W'(h);
      csr_we <= 1'b0;
   endtask

   task automatic test_heat_extremes();
      int k;
      set_size(4, 3);
      for (k = 0; k < 12; k++) send_pixel('1, k == 0);
      set_size(3, 3);
      for (k = 0; k < 9; k++) begin
         send_pixel((k % 3 == 0) ? 8'h00 : ((k % 3 == 1) ? 8'hAA : 8'h55), k == 0);
      end
   endtask

   task automatic test_tiny_sizes();
      set_size(2, 3);
      send_frame(6, 1'b1, 1'b0);
      set_size(2, 4);
      send_frame(8, 1'b1, 1'b0);
      set_size(1, 4);
      send_frame(4, 1'b1, 1'b0);
      set_size(0, 3);
      send_frame(3, 1'b1, 1'b0);
      set_size(5, 2);
      send_frame(10, 1'b1, 1'b0);
      set_size(5, 1);
      send_frame(5, 1'b1, 1'b0);
      set_size(5, 0);
      send_frame(5, 1'b1, 1'b0);
   endtask

   task automatic test_frame_wrap();
      set_size(5, 4);
      steady_flow = 1'b1;
      send_frame(20, 1'b1, 1'b0);
      send_frame(20, 1'b0, 1'b0);
      steady_flow = 1'b0;
      send_frame(20, 1'b1, 1'b1);
      send_frame(20, 1'b1, 1'b0);
   endtask

   task automatic test_out_of_range();
      set_size(8, 6);
      send_frame(3 * 8 + 5, 1'b1, 1'b0);
      set_size(4, 3);
      send_frame(1 + 24, 1'b0, 1'b0);
      set_size(6, 5);
      send_frame(6 * 4 + 2, 1'b1, 1'b0);
      set_size(6, 3);
      send_frame(4 + 18, 1'b0, 1'b0);
   endtask

   task automatic test_size_extremes();
      steady_flow = 1'b1;
      set_size(2047, 3);
      send_frame(40, 1'b1, 1'b0);
      steady_flow = 1'b0;
      set_size(3, 2047);
      send_frame(3 * 40, 1'b1, 1'b0);
   endtask

   task automatic test_random_frames();
      int w, h, f, frames, full, total, roll, first_pixel;
      first_pixel = pixels_sent;
      while (pixels_sent - first_pixel < 800) begin
         roll = $urandom_range(0, 19);
         if (roll < 15) begin
            w = $urandom_range(3, 16);
            h = $urandom_range(3, 8);
         end else if (roll < 18) begin
            w = $urandom_range(17, 64);
            h = $urandom_range(3, 5);
         end else begin
            w = $urandom_range(0, 4);
            h = $urandom_range(0, 4);
         end
         set_size(w, h);
         full = ((w < 1) ? 1 : w) * ((h < 1) ? 1 : h);
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            steady_flow = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 19);
            total = (roll == 0) ? $urandom_range(1, full) : full;
            send_frame(total, f == 0 || $urandom_range(0, 9) != 0, roll == 1);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      int hold;
      rsp_ready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_words.size() == 0) begin
            $error("unexpected word: heat_out %0d, line_end %0d, frame_end %0d",
                   rsp_data.heat_out, rsp_data.line_end, rsp_data.frame_end);
            mismatch_count++;
         end else begin
            want = filtered_words.pop_front();
            if (rsp_data.heat_out !== want.heat_out) begin
               $error("heat_out mismatch: expected %0d, actual %0d",
                      want.heat_out, rsp_data.heat_out);
               mismatch_count++;
            end
            if (rsp_data.line_end !== want.line_end) begin
               $error("line_end mismatch: expected %0d, actual %0d",
                      want.line_end, rsp_data.line_end);
               mismatch_count++;
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               $error("frame_end mismatch: expected %0d, actual %0d",
                      want.frame_end, rsp_data.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int k;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_LINE_WIDTH;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data = '0;
      steady_flow = 1'b0;
      mismatch_count = 0;
      pixels_sent = 0;
      width_reg = LINE_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      for (k = 0; k < MAX_W; k++) begin
         row_above[k] = '0;
         row_above2[k] = '0;
      end
      for (k = 0; k < 9; k++) heat_window[k / 3][k % 3] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_heat_extremes();
      test_tiny_sizes();
      test_frame_wrap();
      test_out_of_range();
      test_size_extremes();
      test_random_frames();
      settle();
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
sv/fbu_pkg.sv
sv/fbu_front.sv
sv/fbu_queue.sv
sv/fbu_back.sv
sv/fire_blur_up_filter_unit.sv
dv/tb_top.sv
